/* rtl/core/bvcs_pkg.sv */
// Shared constants, codes and types of the base vote correction select block.
package bvcs_pkg;

  // Positions at or beyond this bound produce no records
  localparam int unsigned MaxReadLen = 65536;

  // Vote count geometry
  localparam int unsigned CntW     = 12;
  localparam int unsigned NumSubst = 5;   // delete, a, c, g, t
  localparam int unsigned NumIns   = 4;   // a, c, g, t

  // Result queue depth (power of two, at least two)
  localparam int unsigned QueueDepth = 4;

  // Command codes
  localparam logic CmdHeader = 1'b0;
  localparam logic CmdVotes  = 1'b1;

  // Record kinds
  localparam logic [3:0] KindIdent   = 4'd0;
  localparam logic [3:0] KindDelete  = 4'd1;
  localparam logic [3:0] KindSubstA  = 4'd2;
  localparam logic [3:0] KindInsertA = 4'd6;

  // Configuration register indexes
  localparam logic [1:0] CfgDegreeThreshold = 2'd0;
  localparam logic [1:0] CfgHaploMinOccurs  = 2'd1;
  localparam logic [1:0] CfgUseHaploCount   = 2'd2;

  // Thresholds of the selection rules
  localparam logic [CntW-1:0] MinVotes   = CntW'(2);
  localparam logic [CntW-1:0] StrongVote = CntW'(6);

  typedef struct packed {
    logic                     command;
    logic [31:0]              read_id;
    logic [15:0]              deg_l;
    logic [15:0]              deg_r;
    logic [15:0]              position;
    logic [2:0]               base;
    logic [CntW-1:0]          confirmed;
    logic [CntW-1:0]          skip_ins;
    logic [NumSubst*CntW-1:0] subst_votes;
    logic [NumIns*CntW-1:0]   insert_votes;
  } item_t;

  typedef struct packed {
    logic [15:0]     deg_limit;
    logic [CntW-1:0] haplo_min_occurs;
    logic            use_haplo_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] current_read;
    logic        keep_l;
    logic        keep_r;
  } read_state_t;

  typedef struct packed {
    logic [31:0] read_id_res;
    logic        keep_l;
    logic        keep_r;
    logic [3:0]  kind;
    logic [15:0] pos;
    logic        last;
  } record_t;

  typedef struct packed {
    logic [1:0]    valid;      // valid[1] only together with valid[0]
    record_t [1:0] rec;        // rec[0] leaves first
    read_state_t   hdr_state;  // state opened by a header item
  } eval_res_t;

endpackage

/* rtl/core/bvcs_in_if.sv */
// Input item channel: valid/ready handshake with the vote payload.
interface bvcs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] read_id;
  logic [15:0] deg_l;
  logic [15:0] deg_r;
  logic [15:0] position;
  logic [2:0]  base;
  logic [11:0] confirmed;
  logic [11:0] skip_ins;
  logic [59:0] subst_votes;
  logic [47:0] insert_votes;

  modport source (
    output valid, command, read_id, deg_l, deg_r, position, base,
           confirmed, skip_ins, subst_votes, insert_votes,
    input  ready
  );
  modport sink (
    input  valid, command, read_id, deg_l, deg_r, position, base,
           confirmed, skip_ins, subst_votes, insert_votes,
    output ready
  );
endinterface

/* rtl/core/bvcs_out_if.sv */
// Result record channel: valid/ready handshake with the correction record.
interface bvcs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_id_res;
  logic        keep_l;
  logic        keep_r;
  logic [3:0]  kind;
  logic [15:0] pos;
  logic        last;

  modport source (
    output valid, read_id_res, keep_l, keep_r, kind, pos, last,
    input  ready
  );
  modport sink (
    input  valid, read_id_res, keep_l, keep_r, kind, pos, last,
    output ready
  );
endinterface

/* rtl/core/bvcs_cfg_if.sv */
// Configuration write channel: valid/ready handshake with register index and data.
interface bvcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/base_vote_correction_select.sv */
// Top level of the base vote correction select block: input stage, read state, config.
//
// Takes one item per cycle into an input register while the result queue has room;
// the staged item is evaluated, and its zero, one or two records are written into a
// four-entry result queue, whose registered fill count offers them on the output.
// Items that yield at most one record sustain one item per cycle while the output is
// ready; an item that yields both a substitution and an insertion record needs the
// single result port for both records, and the queue absorbs such bursts before the
// input is stalled. There is no clearing pass after reset.
// Configuration writes take effect at once and are always accepted.
module base_vote_correction_select (
  input  logic         clk_i,
  input  logic         rst_ni,
  bvcs_in_if.sink      in_i,
  bvcs_out_if.source   out_o,
  bvcs_cfg_if.sink     cfg_i
);

  bvcs_pkg::item_t       item;
  bvcs_pkg::item_t       stage_q;
  logic                  stage_vld_q, stage_vld_d;
  logic                  in_xfer;
  logic                  advance;
  logic                  space;
  logic [1:0]            push_vld;
  bvcs_pkg::cfg_t        cfg_q, cfg_d;
  bvcs_pkg::read_state_t state_q, state_d;
  bvcs_pkg::eval_res_t   eval_res;
  bvcs_pkg::record_t     rd_rec;

  // Gather the input payload
  always_comb begin
    item.command      = in_i.command;
    item.read_id      = in_i.read_id;
    item.deg_l        = in_i.deg_l;
    item.deg_r        = in_i.deg_r;
    item.position     = in_i.position;
    item.base         = in_i.base;
    item.confirmed    = in_i.confirmed;
    item.skip_ins     = in_i.skip_ins;
    item.subst_votes  = in_i.subst_votes;
    item.insert_votes = in_i.insert_votes;
  end

  // Input stage: refills in the cycle it drains
  assign advance     = stage_vld_q && space;
  assign in_i.ready  = !stage_vld_q || advance;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign stage_vld_d = in_xfer ? 1'b1 : (advance ? 1'b0 : stage_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_q <= item;
    end
  end

  // Configuration registers; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bvcs_pkg::CfgDegreeThreshold: cfg_d.deg_limit        = cfg_i.data;
        bvcs_pkg::CfgHaploMinOccurs:  cfg_d.haplo_min_occurs = cfg_i.data[bvcs_pkg::CntW-1:0];
        bvcs_pkg::CfgUseHaploCount:   cfg_d.use_haplo_count  = cfg_i.data[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deg_limit        <= 16'd2;
      cfg_q.haplo_min_occurs <= bvcs_pkg::CntW'(3);
      cfg_q.use_haplo_count  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Evaluation of the staged item
  bvcs_vote_eval u_eval (
    .item_i  (stage_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .res_o   (eval_res)
  );

  // Read state opened by a header item
  assign state_d = (advance && stage_q.command == bvcs_pkg::CmdHeader) ?
                   eval_res.hdr_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result queue and output channel
  assign push_vld = advance ? eval_res.valid : 2'b00;

  bvcs_rec_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (push_vld),
    .push_rec_i (eval_res.rec),
    .space_o    (space),
    .rd_valid_o (out_o.valid),
    .rd_ready_i (out_o.ready),
    .rd_rec_o   (rd_rec)
  );

  assign out_o.read_id_res = rd_rec.read_id_res;
  assign out_o.keep_l      = rd_rec.keep_l;
  assign out_o.keep_r      = rd_rec.keep_r;
  assign out_o.kind        = rd_rec.kind;
  assign out_o.pos         = rd_rec.pos;
  assign out_o.last        = rd_rec.last;

  // A header always yields exactly its ident record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_q.command == bvcs_pkg::CmdHeader) |-> (push_vld == 2'b01))
    else $error("header did not yield one record");

  // A header updates the read state for the following items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_q.command == bvcs_pkg::CmdHeader) |=>
      (state_q.current_read == $past(stage_q.read_id)))
    else $error("read state not taken from header");

  // Second record slot is used only behind the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_vld[1] |-> (push_vld[0] && !eval_res.rec[0].last && eval_res.rec[1].last))
    else $error("record pair out of order");

endmodule

/* rtl/core/bvcs_vote_eval.sv */
// Vote evaluation: majority winner, total, haplotype and confirmation rules.
module bvcs_vote_eval (
  input  bvcs_pkg::item_t       item_i,
  input  bvcs_pkg::cfg_t        cfg_i,
  input  bvcs_pkg::read_state_t state_i,
  output bvcs_pkg::eval_res_t   res_o
);

  localparam int unsigned CntW    = bvcs_pkg::CntW;
  localparam int unsigned SubIdxW = $clog2(bvcs_pkg::NumSubst);
  localparam int unsigned InsIdxW = $clog2(bvcs_pkg::NumIns);
  localparam int unsigned SubSumW = CntW + $clog2(bvcs_pkg::NumSubst);
  localparam int unsigned InsSumW = CntW + $clog2(bvcs_pkg::NumIns);

  logic [CntW-1:0]               sub_cnt [bvcs_pkg::NumSubst];
  logic [CntW-1:0]               ins_cnt [bvcs_pkg::NumIns];
  logic [SubSumW-1:0]            sub_total;
  logic [InsSumW-1:0]            ins_sum;
  logic [CntW-1:0]               sub_max;
  logic [CntW-1:0]               ins_max;
  logic [SubIdxW-1:0]            sub_win;
  logic [InsIdxW-1:0]            ins_win;
  logic [bvcs_pkg::NumSubst-1:0] sub_haplo;
  logic [bvcs_pkg::NumIns-1:0]   ins_haplo;
  logic                          sub_multi;
  logic                          ins_multi;
  logic                          sub_change;
  logic                          sub_ok;
  logic                          ins_ok;
  logic                          in_range;

  // Unpack counts, sum, haplotype flags and first-strict-maximum search
  always_comb begin
    sub_total = '0;
    sub_max   = '0;
    sub_win   = '0;
    for (int k = 0; k < bvcs_pkg::NumSubst; k++) begin
      sub_cnt[k]   = item_i.subst_votes[k*CntW +: CntW];
      sub_total    = sub_total + SubSumW'(sub_cnt[k]);
      sub_haplo[k] = (sub_cnt[k] >= cfg_i.haplo_min_occurs);
      if (k == 0) begin
        sub_max = sub_cnt[k];
      end else if (sub_cnt[k] > sub_max) begin
        sub_max = sub_cnt[k];
        sub_win = SubIdxW'(k);
      end
    end

    ins_sum = '0;
    ins_max = '0;
    ins_win = '0;
    for (int k = 0; k < bvcs_pkg::NumIns; k++) begin
      ins_cnt[k]   = item_i.insert_votes[k*CntW +: CntW];
      ins_sum      = ins_sum + InsSumW'(ins_cnt[k]);
      ins_haplo[k] = (ins_cnt[k] >= cfg_i.haplo_min_occurs);
      if (k == 0) begin
        ins_max = ins_cnt[k];
      end else if (ins_cnt[k] > ins_max) begin
        ins_max = ins_cnt[k];
        ins_win = InsIdxW'(k);
      end
    end
  end

  // Two or more haplotypes: some set bit remains after clearing the lowest
  assign sub_multi = |(sub_haplo & (sub_haplo - 1'b1));
  assign ins_multi = |(ins_haplo & (ins_haplo - 1'b1));

  // Delete always counts as a change; a letter only if it differs from the base
  assign sub_change = (sub_win == '0) ||
                      ({1'b0, item_i.base} != 4'(sub_win - 1'b1));

  assign in_range = (32'(item_i.position) < 32'(bvcs_pkg::MaxReadLen));

  assign sub_ok = (item_i.confirmed < bvcs_pkg::MinVotes) &&
                  ({2'b00, sub_max, 1'b0} > SubSumW'({1'b0, sub_total})) &&
                  (sub_total > SubSumW'(1)) &&
                  sub_change &&
                  !(sub_multi && cfg_i.use_haplo_count) &&
                  ((item_i.confirmed == '0) || (sub_max > bvcs_pkg::StrongVote));

  assign ins_ok = (item_i.skip_ins < bvcs_pkg::MinVotes) &&
                  ({1'b0, ins_max, 1'b0} > ins_sum) &&
                  (ins_sum > InsSumW'(1)) &&
                  !(ins_multi && cfg_i.use_haplo_count) &&
                  ((item_i.skip_ins == '0) || (ins_max > bvcs_pkg::StrongVote));

  // Header state and record assembly
  always_comb begin
    bvcs_pkg::record_t sub_rec;
    bvcs_pkg::record_t ins_rec;
    bvcs_pkg::record_t hdr_rec;

    res_o.hdr_state.current_read = item_i.read_id;
    res_o.hdr_state.keep_l       = (item_i.deg_l < cfg_i.deg_limit);
    res_o.hdr_state.keep_r       = (item_i.deg_r < cfg_i.deg_limit);

    hdr_rec.read_id_res = item_i.read_id;
    hdr_rec.keep_l      = res_o.hdr_state.keep_l;
    hdr_rec.keep_r      = res_o.hdr_state.keep_r;
    hdr_rec.kind        = bvcs_pkg::KindIdent;
    hdr_rec.pos         = '0;
    hdr_rec.last        = 1'b1;

    sub_rec.read_id_res = state_i.current_read;
    sub_rec.keep_l      = state_i.keep_l;
    sub_rec.keep_r      = state_i.keep_r;
    sub_rec.kind        = bvcs_pkg::KindDelete + 4'(sub_win);
    sub_rec.pos         = item_i.position;
    sub_rec.last        = !ins_ok;

    ins_rec             = sub_rec;
    ins_rec.kind        = bvcs_pkg::KindInsertA + 4'(ins_win);
    ins_rec.last        = 1'b1;

    if (item_i.command == bvcs_pkg::CmdHeader) begin
      res_o.valid  = 2'b01;
      res_o.rec[0] = hdr_rec;
      res_o.rec[1] = ins_rec;
    end else begin
      res_o.valid  = {in_range && sub_ok && ins_ok, in_range && (sub_ok || ins_ok)};
      res_o.rec[0] = sub_ok ? sub_rec : ins_rec;
      res_o.rec[1] = ins_rec;
    end
  end

endmodule

/* rtl/core/bvcs_rec_queue.sv */
// Result record queue: takes up to two records a cycle, releases one a cycle while the reader is ready.
module bvcs_rec_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_vld_i,
  input  bvcs_pkg::record_t [1:0]    push_rec_i,
  output logic                       space_o,
  output logic                       rd_valid_o,
  input  logic                       rd_ready_i,
  output bvcs_pkg::record_t          rd_rec_o
);

  localparam int unsigned Depth = bvcs_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bvcs_pkg::record_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   push_cnt;
  logic              pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign push_cnt   = CntW'(push_vld_i[0]) + CntW'(push_vld_i[1]);
  assign rd_valid_o = (count_q != '0);
  assign rd_rec_o   = mem_q[rd_ptr_q];

  // Room for a full pair of records, independent of this cycle's pop
  assign space_o = (count_q <= CntW'(Depth - 2));

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + push_cnt - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage; the second record lands right after the first
  always_ff @(posedge clk_i) begin
    if (push_vld_i[0]) begin
      mem_q[wr_ptr_q] <= push_rec_i[0];
    end
    if (push_vld_i[1]) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_rec_i[1];
    end
  end

  // Fill count stays within the storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("record queue overfilled");

  // Never push more than the free entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != '0) |-> ((CntW + 1)'(count_q) + (CntW + 1)'(push_cnt) <= (CntW + 1)'(Depth)))
    else $error("push into full record queue");

  // A lone transfer out lowers the fill count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt == '0) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("record queue count lost a transfer");

endmodule

/* sim/base_vote_correction_select_tb.sv */
// Self-checking testbench of the base vote correction select block.
module base_vote_correction_select_tb;

  // Base codes of the input item
  localparam logic [2:0] BaseA = 3'd0;
  localparam logic [2:0] BaseC = 3'd1;
  localparam logic [2:0] BaseG = 3'd2;
  localparam logic [2:0] BaseT = 3'd3;
  localparam logic [2:0] BaseN = 3'd4;

  localparam int QuietLimit = 2000;  // cycles without any transfer before giving up
  localparam int HoldCycles = 300;   // long receiver hold-off
  localparam int TailCycles = 6;     // settle time after the last record

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  bvcs_in_if  in_if ();
  bvcs_out_if out_if ();
  bvcs_cfg_if cfg_if ();

  base_vote_correction_select uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  // Predicted register and read state
  logic [15:0]               deg_thresh  = 16'd2;
  logic [bvcs_pkg::CntW-1:0] hap_min     = 12'd3;
  logic                      hap_rule_on = 1'b0;
  logic [31:0]               open_read   = '0;
  logic                      open_keep_l = 1'b0;
  logic                      open_keep_r = 1'b0;

  bvcs_pkg::item_t   pending_items[$];
  bvcs_pkg::record_t exp_records[$];
  bvcs_pkg::item_t   cur_item;

  int n_errors = 0;
  int in_gap   = 0;
  int out_wait = 0;
  int hold_left;
  int quiet_cycles;
  bit hold_done;
  bit hold_req    = 1'b0;
  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;

  task automatic log_error(input string msg);
    if (n_errors < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic bvcs_pkg::record_t make_record(input logic [3:0] kind,
                                                    input logic [15:0] pos);
    bvcs_pkg::record_t r;
    r.read_id_res = open_read;
    r.keep_l      = open_keep_l;
    r.keep_r      = open_keep_r;
    r.kind        = kind;
    r.pos         = pos;
    r.last        = 1'b0;
    return r;
  endfunction

  // Work out the correction records of one accepted item and queue them
  task automatic predict_records(input bvcs_pkg::item_t it);
    bvcs_pkg::record_t recs[$];
    int unsigned       c, best, total, nhap;
    logic [3:0]        kind;
    bit                change;
    int                k;
    if (it.command == bvcs_pkg::CmdHeader) begin
      open_read   = it.read_id;
      open_keep_l = (it.deg_l < deg_thresh);
      open_keep_r = (it.deg_r < deg_thresh);
      recs.push_back(make_record(bvcs_pkg::KindIdent, 16'd0));
    end else if (it.position < bvcs_pkg::MaxReadLen) begin
      // substitution or delete: delete leads, letters win only when strictly larger
      if (it.confirmed < bvcs_pkg::MinVotes) begin
        kind   = bvcs_pkg::KindDelete;
        best   = 32'(it.subst_votes[bvcs_pkg::CntW-1:0]);
        change = 1'b1;
        total  = 0;
        nhap   = 0;
        for (k = 0; k < bvcs_pkg::NumSubst; k++) begin
          c = 32'(it.subst_votes[bvcs_pkg::CntW*k +: bvcs_pkg::CntW]);
          total += c;
          if (c >= hap_min) nhap++;
          if (k > 0 && c > best) begin
            best   = c;
            kind   = bvcs_pkg::KindDelete + 4'(k);
            change = (it.base != 3'(k - 1));
          end
        end
        if (2 * best > total && total > 1 && change && !(nhap >= 2 && hap_rule_on) &&
            (it.confirmed == 0 || best > bvcs_pkg::StrongVote))
          recs.push_back(make_record(kind, it.position));
      end
      // insertion, independent of the substitution outcome
      if (it.skip_ins < bvcs_pkg::MinVotes) begin
        kind  = bvcs_pkg::KindInsertA;
        best  = 32'(it.insert_votes[bvcs_pkg::CntW-1:0]);
        total = 0;
        nhap  = 0;
        for (k = 0; k < bvcs_pkg::NumIns; k++) begin
          c = 32'(it.insert_votes[bvcs_pkg::CntW*k +: bvcs_pkg::CntW]);
          total += c;
          if (c >= hap_min) nhap++;
          if (c > best) begin
            best = c;
            kind = bvcs_pkg::KindInsertA + 4'(k);
          end
        end
        if (2 * best > total && total > 1 && !(nhap >= 2 && hap_rule_on) &&
            (it.skip_ins == 0 || best > bvcs_pkg::StrongVote))
          recs.push_back(make_record(kind, it.position));
      end
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) exp_records.push_back(recs[i]);
  endtask

  // Item builders
  function automatic bvcs_pkg::item_t header_item(input logic [31:0] id,
                                                  input logic [15:0] l,
                                                  input logic [15:0] r);
    bvcs_pkg::item_t it;
    it         = '0;
    it.command = bvcs_pkg::CmdHeader;
    it.read_id = id;
    it.deg_l   = l;
    it.deg_r   = r;
    return it;
  endfunction

  function automatic bvcs_pkg::item_t votes_item(input logic [15:0] pos,
                                                 input logic [2:0] base,
                                                 input logic [11:0] conf,
                                                 input logic [11:0] noins,
                                                 input logic [59:0] subst,
                                                 input logic [59:0] ins);
    bvcs_pkg::item_t it;
    it              = '0;
    it.command      = bvcs_pkg::CmdVotes;
    it.position     = pos;
    it.base         = base;
    it.confirmed    = conf;
    it.skip_ins     = noins;
    it.subst_votes  = subst;
    it.insert_votes = ins[bvcs_pkg::NumIns*bvcs_pkg::CntW-1:0];
    return it;
  endfunction

  // Counts given highest slot first
  function automatic logic [59:0] pack_votes(input int c4, input int c3, input int c2,
                                             input int c1, input int c0);
    return {12'(c4), 12'(c3), 12'(c2), 12'(c1), 12'(c0)};
  endfunction

  // Vote tallies shaped toward majorities, ties, tiny totals and full-range noise
  function automatic logic [59:0] random_votes(input int n);
    logic [59:0] v;
    int          mode, win, k;
    logic [11:0] tie, big;
    v    = '0;
    mode = $urandom_range(0, 9);
    win  = $urandom_range(0, n - 1);
    tie  = 12'($urandom_range(1, 40));
    big  = $urandom_range(0, 1) ? 12'($urandom_range(1, 24)) : 12'($urandom_range(0, 4095));
    for (k = 0; k < n; k++) begin
      case (mode)
        0, 1, 2, 3, 4: v[12*k +: 12] = (k == win) ? big : 12'($urandom_range(0, 4));
        5, 6:          v[12*k +: 12] = 12'($urandom_range(0, 3));
        7: v[12*k +: 12] = (k == win || k == (win + 1) % n) ? tie
                                                             : 12'($urandom_range(0, 2));
        8:       v[12*k +: 12] = 12'($urandom_range(0, 4095));
        default: v[12*k +: 12] = (k == win) ? 12'($urandom_range(0, 1)) : 12'd0;
      endcase
    end
    return v;
  endfunction

  // Mostly near the vote gate, sometimes anywhere
  function automatic logic [11:0] random_gate_count();
    return ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2));
  endfunction

  // Half the degrees straddle the threshold
  function automatic logic [15:0] random_degree();
    return $urandom_range(0, 1) ? 16'($urandom)
                                : 16'(int'(deg_thresh) + $urandom_range(0, 2) - 1);
  endfunction

  // Reads: a header followed by a run of positions, plus some noise items
  task automatic queue_reads(input int n_items);
    int              k, run;
    logic [15:0]     pos;
    logic [2:0]      base;
    bvcs_pkg::item_t it;
    while (n_items > 0) begin
      if ($urandom_range(0, 15) == 0) begin
        it.command      = 1'($urandom_range(0, 1));
        it.read_id      = $urandom;
        it.deg_l        = 16'($urandom);
        it.deg_r        = 16'($urandom);
        it.position     = 16'($urandom);
        it.base         = 3'($urandom);
        it.confirmed    = 12'($urandom);
        it.skip_ins     = 12'($urandom);
        it.subst_votes  = 60'({$urandom, $urandom});
        it.insert_votes = 48'({$urandom, $urandom});
        pending_items.push_back(it);
        n_items--;
      end else begin
        pending_items.push_back(header_item($urandom, random_degree(), random_degree()));
        run = $urandom_range(3, 25);
        pos = 16'($urandom);
        for (k = 0; k < run; k++) begin
          base = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7))
                                             : 3'($urandom_range(0, 3));
          pending_items.push_back(votes_item(pos + 16'(k), base, random_gate_count(),
                                             random_gate_count(),
                                             random_votes(bvcs_pkg::NumSubst),
                                             random_votes(bvcs_pkg::NumIns)));
        end
        n_items -= run + 1;
      end
    end
  endtask

  // Register write, block idle; mirrors the register in the prediction
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      bvcs_pkg::CfgDegreeThreshold: deg_thresh  = val;
      bvcs_pkg::CfgHaploMinOccurs:  hap_min     = val[bvcs_pkg::CntW-1:0];
      bvcs_pkg::CfgUseHaploCount:   hap_rule_on = val[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every item went in and every expected record came out
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || exp_records.size() != 0);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Input driver: per-item gap, holds the item until transfer
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.command      <= bvcs_pkg::CmdHeader;
      in_if.read_id      <= '0;
      in_if.deg_l        <= '0;
      in_if.deg_r        <= '0;
      in_if.position     <= '0;
      in_if.base         <= '0;
      in_if.confirmed    <= '0;
      in_if.skip_ins     <= '0;
      in_if.subst_votes  <= '0;
      in_if.insert_votes <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_records(cur_item);
        in_gap = in_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_if.valid        <= 1'b1;
          in_if.command      <= cur_item.command;
          in_if.read_id      <= cur_item.read_id;
          in_if.deg_l        <= cur_item.deg_l;
          in_if.deg_r        <= cur_item.deg_r;
          in_if.position     <= cur_item.position;
          in_if.base         <= cur_item.base;
          in_if.confirmed    <= cur_item.confirmed;
          in_if.skip_ins     <= cur_item.skip_ins;
          in_if.subst_votes  <= cur_item.subst_votes;
          in_if.insert_votes <= cur_item.insert_votes;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Output monitor: compares each record with the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    bvcs_pkg::record_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_records.size() == 0) begin
          log_error($sformatf("record kind %0d pos %0h with nothing expected",
                              out_if.kind, out_if.pos));
        end else begin
          e = exp_records.pop_front();
          if (out_if.read_id_res !== e.read_id_res)
            log_error($sformatf("read_id_res %h, expected %h", out_if.read_id_res,
                                e.read_id_res));
          if (out_if.keep_l !== e.keep_l)
            log_error($sformatf("keep_l %b, expected %b", out_if.keep_l, e.keep_l));
          if (out_if.keep_r !== e.keep_r)
            log_error($sformatf("keep_r %b, expected %b", out_if.keep_r, e.keep_r));
          if (out_if.kind !== e.kind)
            log_error($sformatf("kind %0d, expected %0d", out_if.kind, e.kind));
          if (out_if.pos !== e.pos)
            log_error($sformatf("pos %h, expected %h", out_if.pos, e.pos));
          if (out_if.last !== e.last)
            log_error($sformatf("last %b, expected %b", out_if.last, e.last));
        end
        out_wait = out_idle_on ? $urandom_range(0, 6) : 0;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_if.ready <= (out_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Phases: directed items at reset settings, then random reads under several settings
  initial begin
    int ph;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= bvcs_pkg::CfgDegreeThreshold;
    cfg_if.data  <= '0;
    rst_n        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    // votes ahead of any header: delete and insert t under read 0
    pending_items.push_back(votes_item(16'd0, BaseA, 12'd0, 12'd0,
                                       pack_votes(0, 0, 0, 0, 5), pack_votes(0, 9, 0, 0, 0)));
    // headers: degree extremes and the threshold edge
    pending_items.push_back(header_item(32'hFFFF_FFFF, 16'd0, 16'd0));
    pending_items.push_back(header_item(32'h1234_5678, 16'hFFFF, 16'd1));
    pending_items.push_back(header_item(32'hA5A5_5A5A, 16'd2, 16'd2));
    pending_items.push_back(header_item(32'h0000_0000, 16'd1, 16'hFFFF));
    // other bases: a letter winner is a change; insert gated off for the first
    pending_items.push_back(votes_item(16'hFFFF, BaseN, 12'd0, 12'd2,
                                       pack_votes(0, 0, 0, 3, 0), pack_votes(0, 0, 0, 0, 9)));
    pending_items.push_back(votes_item(16'd1, 3'd7, 12'd1, 12'd1,
                                       pack_votes(4095, 0, 0, 0, 0), pack_votes(0, 0, 0, 0, 7)));
    // one confirming vote needs more than six for the winner
    pending_items.push_back(votes_item(16'd2, BaseA, 12'd1, 12'd1,
                                       pack_votes(0, 0, 6, 0, 0), pack_votes(0, 0, 6, 0, 0)));
    // winner equals the current base
    pending_items.push_back(votes_item(16'd3, BaseG, 12'd0, 12'd0,
                                       pack_votes(0, 10, 0, 0, 0), pack_votes(0, 0, 0, 2, 0)));
    // ties go to the earlier candidate and fail the strict majority
    pending_items.push_back(votes_item(16'd4, BaseT, 12'd0, 12'd0,
                                       pack_votes(0, 0, 5, 5, 0), pack_votes(0, 3, 0, 3, 0)));
    pending_items.push_back(votes_item(16'd5, BaseT, 12'd0, 12'd0,
                                       pack_votes(0, 0, 4, 0, 4), pack_votes(0, 0, 0, 4, 4)));
    // total of one
    pending_items.push_back(votes_item(16'd6, BaseC, 12'd0, 12'd0,
                                       pack_votes(0, 0, 0, 0, 1), pack_votes(0, 0, 0, 0, 1)));
    // substitution gates closed; the second item leaves the insert gate open
    pending_items.push_back(votes_item(16'd7, BaseC, 12'd2, 12'hFFF,
                                       pack_votes(0, 0, 0, 9, 0), pack_votes(0, 0, 0, 0, 9)));
    pending_items.push_back(votes_item(16'd8, BaseC, 12'hFFF, 12'd0,
                                       pack_votes(0, 0, 0, 9, 0), pack_votes(0, 0, 0, 4, 5)));
    // all counts full
    pending_items.push_back(votes_item(16'd9, BaseA, 12'd0, 12'd0,
                                       pack_votes(4095, 4095, 4095, 4095, 4095),
                                       pack_votes(0, 4095, 4095, 4095, 4095)));
    // two haplotypes with the count rule off
    pending_items.push_back(votes_item(16'd10, BaseG, 12'd0, 12'd1,
                                       pack_votes(0, 0, 3, 10, 0), pack_votes(0, 5, 20, 0, 0)));
    pending_items.push_back(votes_item(16'd11, BaseA, 12'd0, 12'd0,
                                       pack_votes(0, 0, 8, 0, 0), pack_votes(0, 0, 0, 0, 0)));
    pending_items.push_back(votes_item(16'h8000, BaseC, 12'd1, 12'd0,
                                       pack_votes(0, 8, 0, 0, 0), pack_votes(0, 8, 0, 0, 0)));
    pending_items.push_back(votes_item(16'd12, BaseN, 12'd0, 12'd0,
                                       pack_votes(8, 0, 0, 0, 0), pack_votes(0, 0, 0, 0, 0)));
    drain();

    for (ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          cfg_write(bvcs_pkg::CfgDegreeThreshold, 16'd0);
          cfg_write(bvcs_pkg::CfgHaploMinOccurs, 16'd0);
          cfg_write(bvcs_pkg::CfgUseHaploCount, 16'd1);
        end
        2: begin
          cfg_write(bvcs_pkg::CfgDegreeThreshold, 16'hFFFF);
          cfg_write(bvcs_pkg::CfgHaploMinOccurs, 16'hFFFF);
          cfg_write(bvcs_pkg::CfgUseHaploCount, 16'hFFFF);
        end
        3: begin
          cfg_write(bvcs_pkg::CfgDegreeThreshold, 16'($urandom));
          cfg_write(bvcs_pkg::CfgHaploMinOccurs, {4'($urandom), 12'($urandom_range(2, 6))});
          cfg_write(bvcs_pkg::CfgUseHaploCount, {15'($urandom), 1'b1});
        end
        4: begin
          cfg_write(bvcs_pkg::CfgDegreeThreshold, 16'($urandom_range(1, 8)));
          cfg_write(bvcs_pkg::CfgHaploMinOccurs, 16'd3);
          cfg_write(bvcs_pkg::CfgUseHaploCount, 16'hFFFE);
        end
        default: begin
          cfg_write(bvcs_pkg::CfgDegreeThreshold, 16'd2);
          cfg_write(bvcs_pkg::CfgHaploMinOccurs, 16'd1);
          cfg_write(bvcs_pkg::CfgUseHaploCount, 16'd0);
        end
      endcase
      @(negedge clk);
      in_idle_on  = (ph == 2 || ph == 4) ? 1'b1
                  : (ph == 3) ? 1'($urandom_range(0, 1)) : 1'b0;
      out_idle_on = (ph == 2 || ph == 5) ? 1'b1
                  : (ph == 3) ? 1'($urandom_range(0, 1)) : 1'b0;
      if (ph == 2) hold_req = 1'b1;
      queue_reads(ph == 5 ? 280 : 300);
      drain();
    end

    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* base_vote_correction_select.f */
rtl/core/bvcs_pkg.sv
rtl/core/bvcs_in_if.sv
rtl/core/bvcs_out_if.sv
rtl/core/bvcs_cfg_if.sv
rtl/core/bvcs_vote_eval.sv
rtl/core/bvcs_rec_queue.sv
rtl/core/base_vote_correction_select.sv
sim/base_vote_correction_select_tb.sv
